// File: src/bos_pkg.sv
// Shared types, sizes and codes for the byte operand stack.
`default_nettype none
package bos_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int BYTE_W      = 8;
  localparam int VALUE_W     = 64;
  localparam int MAX_BYTES   = VALUE_W / BYTE_W;
  localparam int REM_W       = $clog2(MAX_BYTES + 1);
  localparam int FILL_W      = 11;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic               func;
    logic [1:0]         size_code;
    logic [VALUE_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] pop_value;
    logic [1:0]         status;
    logic [FILL_W-1:0]  fill_level;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PUSH,
    S_POP_FIRST,
    S_POP,
    S_POP_TAIL,
    S_DONE
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic wr_step;
    logic rd_step;
    logic capture;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic pop;
    logic err;
    logic rem_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// File: src/bos_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: src/bos_ctrl.sv
// Sequencer for the byte operand stack: checks, byte loop and result hand-off.
`default_nettype none
module bos_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  bos_pkg::dp_status_t stat,
  output bos_pkg::ctl_cmd_t   cmd
);

  bos_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bos_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bos_pkg::S_IDLE: begin
        if (req_valid) state_next = bos_pkg::S_CHECK;
      end
      bos_pkg::S_CHECK: begin
        if (stat.err) state_next = bos_pkg::S_DONE;
        else if (stat.pop) state_next = bos_pkg::S_POP_FIRST;
        else state_next = bos_pkg::S_PUSH;
      end
      bos_pkg::S_PUSH: begin
        if (stat.rem_last) state_next = bos_pkg::S_DONE;
      end
      bos_pkg::S_POP_FIRST: begin
        if (stat.rem_last) state_next = bos_pkg::S_POP_TAIL;
        else state_next = bos_pkg::S_POP;
      end
      bos_pkg::S_POP: begin
        if (stat.rem_last) state_next = bos_pkg::S_POP_TAIL;
      end
      bos_pkg::S_POP_TAIL: begin
        state_next = bos_pkg::S_DONE;
      end
      bos_pkg::S_DONE: begin
        if (stat.out_free) state_next = bos_pkg::S_IDLE;
      end
      default: state_next = bos_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    case (state)
      bos_pkg::S_IDLE: begin
        // No item is taken while reset is held.
        req_stall = rst;
        cmd.load  = req_valid && !rst;
      end
      bos_pkg::S_CHECK:     cmd.check = 1'b1;
      bos_pkg::S_PUSH:      cmd.wr_step = 1'b1;
      bos_pkg::S_POP_FIRST: cmd.rd_step = 1'b1;
      bos_pkg::S_POP: begin
        cmd.rd_step = 1'b1;
        cmd.capture = 1'b1;
      end
      bos_pkg::S_POP_TAIL:  cmd.capture = 1'b1;
      bos_pkg::S_DONE:      cmd.finish = stat.out_free;
      default: begin
        cmd       = '0;
        req_stall = 1'b1;
      end
    endcase
  end

  // Reads and writes of the byte store never share a cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_step && cmd.rd_step))
    else $error("byte store read and write in the same cycle");

  // A result is only loaded when the output register can take it.
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> stat.out_free)
    else $error("result loaded into a busy output register");

  // A failed check skips the byte loop entirely.
  a_err_skips: assert property (@(posedge clk) disable iff (rst)
    (state == bos_pkg::S_CHECK && stat.err) |=> state == bos_pkg::S_DONE)
    else $error("rejected operation entered the byte loop");

endmodule
`default_nettype wire

// File: src/bos_dpath.sv
// Datapath of the byte operand stack: count, byte store, shifters and output register.
`default_nettype none
module bos_dpath (
  input  logic                clk,
  input  logic                rst,
  input  bos_pkg::req_t       req,
  input  bos_pkg::ctl_cmd_t   cmd,
  output bos_pkg::dp_status_t stat,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output bos_pkg::rsp_t       rsp
);

  logic                          op_pop;
  logic [bos_pkg::REM_W-1:0]     rem;
  logic [bos_pkg::VALUE_W-1:0]   shreg;
  logic [bos_pkg::VALUE_W-1:0]   acc;
  logic [1:0]                    status_r;
  logic [bos_pkg::CNT_W-1:0]     count;
  logic [bos_pkg::CNT_W-1:0]     count_dec;
  logic [bos_pkg::CNT_W:0]       count_ext;
  logic [bos_pkg::CNT_W:0]       n_ext;
  logic                          err_pop;
  logic                          err_push;
  logic [bos_pkg::BYTE_W-1:0]    rdata;

  assign count_dec = count - bos_pkg::CNT_W'(1);
  assign count_ext = {1'b0, count};
  assign n_ext     = (bos_pkg::CNT_W + 1)'(rem);
  assign err_pop   = count_ext < n_ext;
  assign err_push  = (count_ext + n_ext) > (bos_pkg::CNT_W + 1)'(bos_pkg::STACK_DEPTH);

  assign stat.pop      = op_pop;
  assign stat.err      = op_pop ? err_pop : err_push;
  assign stat.rem_last = (rem == bos_pkg::REM_W'(1));
  assign stat.out_free = !rsp_valid || !rsp_stall;

  bos_ram #(
    .WIDTH(bos_pkg::BYTE_W),
    .DEPTH(bos_pkg::STACK_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_step),
    .waddr (count[bos_pkg::ADDR_W-1:0]),
    .wdata (shreg[bos_pkg::BYTE_W-1:0]),
    .re    (cmd.rd_step),
    .raddr (count_dec[bos_pkg::ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_pop <= (req.func == bos_pkg::FUNC_POP);
      rem    <= bos_pkg::REM_W'(1) << req.size_code;
      shreg  <= req.push_value;
      acc    <= '0;
    end else begin
      if (cmd.wr_step || cmd.rd_step) rem <= rem - bos_pkg::REM_W'(1);
      if (cmd.wr_step) shreg <= shreg >> bos_pkg::BYTE_W;
      if (cmd.capture) acc <= {acc[bos_pkg::VALUE_W-bos_pkg::BYTE_W-1:0], rdata};
    end
    if (cmd.check) begin
      if (!stat.err) status_r <= bos_pkg::ST_OK;
      else if (op_pop) status_r <= bos_pkg::ST_UNDERFLOW;
      else status_r <= bos_pkg::ST_OVERFLOW;
    end
    if (cmd.finish) begin
      rsp.pop_value  <= acc;
      rsp.status     <= status_r;
      rsp.fill_level <= bos_pkg::FILL_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.wr_step) count <= count + bos_pkg::CNT_W'(1);
      else if (cmd.rd_step) count <= count_dec;
      if (cmd.finish) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  // The byte count never passes the capacity of the store.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bos_pkg::CNT_W'(bos_pkg::STACK_DEPTH))
    else $error("byte count beyond stack capacity");

  // The count moves by at most one byte per cycle.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ##1 (count == $past(count) || count == $past(count) + bos_pkg::CNT_W'(1) ||
         count == $past(count) - bos_pkg::CNT_W'(1)))
    else $error("byte count jumped");

  // A rejected operation always reports a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != bos_pkg::ST_OK) |-> rsp.pop_value == '0)
    else $error("nonzero value on a rejected operation");

endmodule
`default_nettype wire

// File: src/byte_operand_stack_multiwidth_top.sv
// Top level of the byte-addressed operand stack with 1, 2, 4 and 8 byte operands.
//
//   Channel | Signals                   | Direction | Contents
//   --------+---------------------------+-----------+--------------------------------
//   req     | req_valid, req_stall, req | in        | func, size_code, push_value
//   rsp     | rsp_valid, rsp_stall, rsp | out       | pop_value, status, fill_level
//
// An item passes through the accept state, the bounds check, one step per byte
// moved through the byte-wide stack memory, and a step that loads the result
// register. A pop takes one more step because of the registered memory read,
// and a rejected item goes from the check straight to the result load. Reset
// clears the byte count and both handshakes; the memory contents are not
// cleared and need no clearing pass. A result that waits under rsp_stall
// holds its value, and the next item is taken and processed meanwhile,
// holding only in the final step until the output register is free.
`default_nettype none
module byte_operand_stack_multiwidth_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  bos_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output bos_pkg::rsp_t rsp
);

  // Command and status groups between the sequencer and the datapath.
  bos_pkg::ctl_cmd_t   cmd;
  bos_pkg::dp_status_t stat;

  // The sequencer walks each item through check, byte loop and hand-off.
  bos_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the byte count, the byte store and the result register.
  bos_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the byte-addressed operand stack with multi-width operands.
module tb_top;
  import bos_pkg::*;

  // Operand width codes as carried in size_code.
  localparam logic [1:0] SZ_1B = 2'd0;
  localparam logic [1:0] SZ_2B = 2'd1;
  localparam logic [1:0] SZ_4B = 2'd2;
  localparam logic [1:0] SZ_8B = 2'd3;

  // Receiver hold-off used to back the block up until it stalls its input.
  localparam int HOLD_OFF_CYCLES = 200;
  // Random items per idling phase.
  localparam int PHASE_ITEMS     = 220;

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req       = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;

  byte_operand_stack_multiwidth_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Shadow copy of the stack: the byte store and the number of bytes held.
  logic [7:0] stack_mem [STACK_DEPTH];
  int         stack_fill = 0;

  // Results still owed by the block, oldest first.
  rsp_t       expected_rsps[$];
  int         mismatch_count = 0;
  int         items_done     = 0;

  // Idling knobs, set by the stimulus process and read by both sides.
  int         send_idle_pct  = 0;
  int         rsp_stall_pct  = 0;
  // Each increment asks the result side for one long hold-off.
  int         hold_requests  = 0;

  // One row of the directed table. A row may be repeated, may take a random
  // push value, and may carry a result typed in by hand.
  typedef struct {
    logic        func;
    logic [1:0]  size_code;
    logic [63:0] value;
    bit          rnd;
    int          reps;
    bit          typed;
    rsp_t        exp;
  } dir_row_t;

  dir_row_t dir_rows[$];

  // Applies one item to the shadow stack and returns the result it must give.
  // A push stores the operand low byte first; a pop reads the newest byte as
  // the most significant one. Rejected items leave the stack untouched.
  function automatic rsp_t stack_apply(input req_t r);
    rsp_t res;
    int   nbytes;
    res    = '0;
    nbytes = 1 << r.size_code;
    if (r.func == FUNC_PUSH) begin
      if (stack_fill + nbytes > STACK_DEPTH) begin
        res.status = ST_OVERFLOW;
      end else begin
        for (int i = 0; i < nbytes; i++) begin
          stack_mem[stack_fill] = r.push_value[8*i +: 8];
          stack_fill++;
        end
      end
    end else begin
      if (stack_fill < nbytes) begin
        res.status = ST_UNDERFLOW;
      end else begin
        for (int i = 0; i < nbytes; i++) begin
          stack_fill--;
          res.pop_value = {res.pop_value[VALUE_W-9:0], stack_mem[stack_fill]};
        end
      end
    end
    res.fill_level = FILL_W'(stack_fill);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 200) begin
      $display("ERROR at %0t: %s got %h expected %h", $time, what, got, want);
    end
  endtask

  task automatic add_row(input logic func, input logic [1:0] size_code,
                         input logic [63:0] value, input bit rnd, input int reps,
                         input bit typed, input logic [63:0] pop_value,
                         input logic [1:0] status, input int fill);
    dir_row_t row;
    row.func             = func;
    row.size_code        = size_code;
    row.value            = value;
    row.rnd              = rnd;
    row.reps             = reps;
    row.typed            = typed;
    row.exp.pop_value    = pop_value;
    row.exp.status       = status;
    row.exp.fill_level   = FILL_W'(fill);
    dir_rows = {dir_rows, row};
  endtask

  // Offers one item, with a random idle gap ahead of it, and waits until the
  // block takes it. The shadow stack is updated at the edge of acceptance, so
  // the expectation is queued before the block can possibly answer. A typed
  // result replaces the computed one in the queue.
  task automatic offer_item(input logic func, input logic [1:0] size_code,
                            input logic [63:0] value, input bit typed,
                            input rsp_t typed_rsp, output rsp_t predicted);
    req_t r;
    rsp_t queued;
    r.func       = func;
    r.size_code  = size_code;
    r.push_value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = stack_apply(r);
    queued    = typed ? typed_rsp : predicted;
    expected_rsps = {expected_rsps, queued};
    items_done++;
  endtask

  // Result side: checks every accepted result against the oldest expectation
  // and drives rsp_stall for the next edge, either at random or as one long
  // hold-off when the stimulus asks for it.
  initial begin
    rsp_t want;
    int   hold_served;
    int   hold_left;
    hold_served = 0;
    hold_left   = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("result with none expected, pop_value", rsp.pop_value, '0);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.pop_value !== want.pop_value)
            report_mismatch("pop_value", rsp.pop_value, want.pop_value);
          if (rsp.status !== want.status)
            report_mismatch("status", 64'(rsp.status), 64'(want.status));
          if (rsp.fill_level !== want.fill_level)
            report_mismatch("fill_level", 64'(rsp.fill_level), 64'(want.fill_level));
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
    end
  end

  // Stimulus: a directed table first, then random episodes in four idling phases.
  initial begin
    int          idle_plan  [4];
    int          stall_plan [4];
    int          kind;
    int          ep_len;
    int          max_len;
    int          push_pct;
    int          hits;
    int          phase_end;
    int          spins;
    bit          do_push;
    logic [1:0]  sz;
    logic [1:0]  stop_status;
    logic [1:0]  pushed_sizes[$];
    rsp_t        got_rsp;

    idle_plan  = '{0, 66, 0, 23};
    stall_plan = '{0, 0, 66, 23};

    // Directed rows. Typed results follow directly from the byte order: the
    // last byte pushed is the top of the stack and comes out as the MSB.
    // Pops from an empty stack, both the smallest and the largest.
    add_row(FUNC_POP,  SZ_1B, '0, 0, 1, 1, '0, ST_UNDERFLOW, 0);
    add_row(FUNC_POP,  SZ_8B, '1, 0, 1, 1, '0, ST_UNDERFLOW, 0);
    // All-ones operand in and out.
    add_row(FUNC_PUSH, SZ_8B, '1, 0, 1, 1, '0, ST_OK, 8);
    add_row(FUNC_POP,  SZ_8B, '0, 0, 1, 1, '1, ST_OK, 0);
    // One wide push taken apart by narrower pops, with a short underflow.
    add_row(FUNC_PUSH, SZ_8B, 64'h0123_4567_89AB_CDEF, 0, 1, 1, '0, ST_OK, 8);
    add_row(FUNC_POP,  SZ_1B, '0, 0, 1, 1, 64'h01, ST_OK, 7);
    add_row(FUNC_POP,  SZ_2B, '0, 0, 1, 1, 64'h2345, ST_OK, 5);
    add_row(FUNC_POP,  SZ_4B, '0, 0, 1, 1, 64'h6789_ABCD, ST_OK, 1);
    add_row(FUNC_POP,  SZ_2B, '0, 0, 1, 1, '0, ST_UNDERFLOW, 1);
    add_row(FUNC_POP,  SZ_1B, '0, 0, 1, 1, 64'hEF, ST_OK, 0);
    // Narrow pushes must drop the upper bits of push_value.
    add_row(FUNC_PUSH, SZ_1B, 64'hFFFF_FFFF_FFFF_FF5A, 0, 1, 1, '0, ST_OK, 1);
    add_row(FUNC_PUSH, SZ_2B, 64'h0, 0, 1, 1, '0, ST_OK, 3);
    add_row(FUNC_PUSH, SZ_4B, 64'hDEAD_BEEF_8BAD_F00D, 0, 1, 1, '0, ST_OK, 7);
    add_row(FUNC_POP,  SZ_8B, '0, 0, 1, 1, '0, ST_UNDERFLOW, 7);
    add_row(FUNC_PUSH, SZ_1B, 64'h80, 0, 1, 1, '0, ST_OK, 8);
    add_row(FUNC_POP,  SZ_8B, '0, 0, 1, 0, '0, ST_OK, 0);
    // Fill the stack to the brim, then try to push past it.
    add_row(FUNC_PUSH, SZ_8B, '0, 1, STACK_DEPTH / 8, 0, '0, ST_OK, 0);
    add_row(FUNC_PUSH, SZ_1B, '1, 0, 1, 1, '0, ST_OVERFLOW, STACK_DEPTH);
    add_row(FUNC_PUSH, SZ_8B, '1, 0, 1, 1, '0, ST_OVERFLOW, STACK_DEPTH);
    add_row(FUNC_POP,  SZ_8B, '0, 0, 1, 0, '0, ST_OK, 0);
    add_row(FUNC_PUSH, SZ_4B, '0, 1, 1, 0, '0, ST_OK, 0);
    add_row(FUNC_PUSH, SZ_4B, '1, 0, 1, 1, '0, ST_OK, STACK_DEPTH);
    add_row(FUNC_PUSH, SZ_2B, '0, 1, 1, 1, '0, ST_OVERFLOW, STACK_DEPTH);
    add_row(FUNC_POP,  SZ_4B, '0, 0, 1, 0, '0, ST_OK, 0);
    add_row(FUNC_POP,  SZ_2B, '0, 0, 1, 0, '0, ST_OK, 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      repeat (dir_rows[k].reps) begin
        offer_item(dir_rows[k].func, dir_rows[k].size_code,
                   dir_rows[k].rnd ? {$urandom, $urandom} : dir_rows[k].value,
                   dir_rows[k].typed, dir_rows[k].exp, got_rsp);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_plan[ph];
      rsp_stall_pct = stall_plan[ph];
      // With the sender at full rate, one long hold-off on the result side
      // backs the block up until it stalls its input.
      if (ph == 0) hold_requests++;
      phase_end = items_done + PHASE_ITEMS;
      while (items_done < phase_end) begin
        kind = $urandom_range(9);
        if (kind < 3) begin
          // Matched pushes and pops: each pop returns the operand pushed.
          pushed_sizes.delete();
          repeat ($urandom_range(1, 12)) begin
            sz = 2'($urandom_range(3));
            pushed_sizes = {pushed_sizes, sz};
            offer_item(FUNC_PUSH, sz, {$urandom, $urandom}, 1'b0, '0, got_rsp);
          end
          while (pushed_sizes.size() != 0) begin
            sz = pushed_sizes[pushed_sizes.size() - 1];
            pushed_sizes.delete(pushed_sizes.size() - 1);
            offer_item(FUNC_POP, sz, {$urandom, $urandom}, 1'b0, '0, got_rsp);
          end
        end else begin
          // Random walk. Fill and drain runs are steered toward a full or an
          // empty stack and stop after running into the bound twice or after 250
          // items; a balanced run mixes pushes and pops of unrelated widths.
          case (kind)
            3, 4, 5: begin
              push_pct = 92; max_len = 250; stop_status = ST_OVERFLOW;
            end
            6, 7: begin
              push_pct = 8;  max_len = 250; stop_status = ST_UNDERFLOW;
            end
            default: begin
              push_pct = 50; max_len = $urandom_range(20, 60); stop_status = ST_OK;
            end
          endcase
          hits   = 0;
          ep_len = 0;
          while (hits < 2 && ep_len < max_len) begin
            do_push = ($urandom_range(99) < push_pct);
            sz = (push_pct != 50 && $urandom_range(1) == 1) ? SZ_8B
                                                            : 2'($urandom_range(3));
            offer_item(do_push ? FUNC_PUSH : FUNC_POP, sz, {$urandom, $urandom},
                       1'b0, '0, got_rsp);
            if (stop_status != ST_OK && got_rsp.status == stop_status) hits++;
            ep_len++;
          end
        end
      end
    end

    req_valid    <= 1'b0;
    rsp_stall_pct = 0;
    spins         = 0;
    while (expected_rsps.size() != 0 && spins < 20000) begin
      @(posedge clk);
      spins++;
    end
    // A further wait, longer than the longest item takes, to catch stray results.
    repeat (30) @(posedge clk);
    if (expected_rsps.size() != 0) begin
      report_mismatch("results never delivered, count", 64'(expected_rsps.size()), '0);
    end
    if (mismatch_count == 0) begin
      $display("byte_operand_stack_multiwidth_top: match");
    end else begin
      $display("byte_operand_stack_multiwidth_top: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("byte_operand_stack_multiwidth_top: mismatch");
    $finish;
  end

endmodule
